[hw/rtl/ggpc_pkg.sv]
// ----------------------------------------------------------------------------
// ggpc_pkg
// Shared widths, constants, register indexes and types for the go-to-goal
// proportional controller pipeline.
// ----------------------------------------------------------------------------
package ggpc_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    localparam int POS_W        = 32;             // position fields, signed
    localparam int YAW_W        = 16;             // yaw field, signed
    localparam int GAIN_W       = 16;             // gain, unsigned Q0.16
    localparam int DIFF_W       = POS_W + 1;      // goal error
    localparam int SQ_W         = 2 * POS_W + 1;  // square of one error magnitude
    localparam int RAD_W        = SQ_W + 1;       // sum of squares
    localparam int ROOT_W       = RAD_W / 2;      // floor square root
    localparam int REM_W        = ROOT_W + 3;     // partial remainder
    localparam int CORD_W       = POS_W + 4;      // CORDIC x and y
    localparam int Z_W          = 32;             // CORDIC angle, 2^32 per turn
    localparam int CORDIC_ITERS = 32;
    localparam int LIN_W        = 34;
    localparam int ANG_W        = 20;
    localparam int ANG_MAX      = 327680;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

    localparam int FRONT_LAT  = 2;
    localparam int SQRT_LAT   = ROOT_W + 1;
    localparam int CORDIC_LAT = CORDIC_ITERS + 2;
    localparam int CMD_LAT    = 2;
    localparam int PIPE_LAT   = FRONT_LAT + SQRT_LAT + CMD_LAT;

    // atan(2^-i), 2^32 units per turn
    localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [1:0] {
        REG_GOAL_X = 2'd0,
        REG_GOAL_Y = 2'd1,
        REG_GAIN   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [SQ_W-1:0]          sq_a;
        logic [SQ_W-1:0]          sq_b;
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic [Z_W-1:0]           cz;
        logic                     at_goal;
    } front_t;

    typedef struct packed {
        logic neg;
        logic at_goal;
    } head_flags_t;

    typedef struct packed {
        logic [LIN_W-1:0] linear_cmd;
        logic [ANG_W-1:0] angular_cmd;
        logic             arrived;
    } result_t;

endpackage

[hw/rtl/ggpc_front.sv]
// ----------------------------------------------------------------------------
// ggpc_front
// Goal error, yaw wrap, error squares and CORDIC pre-rotation (two stages).
// ----------------------------------------------------------------------------
module ggpc_front
    import ggpc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [POS_W-1:0]  robot_x,
    input  logic signed [POS_W-1:0]  robot_y,
    input  logic signed [YAW_W-1:0]  yaw_angle,
    input  logic signed [POS_W-1:0]  goal_x,
    input  logic signed [POS_W-1:0]  goal_y,
    output front_t                   front,
    output logic [ANGLE_BITS-1:0]    yaw_w
);

    localparam int YAW_EXT_W = (ANGLE_BITS > YAW_W) ? ANGLE_BITS : YAW_W;

    logic signed [DIFF_W-1:0]    ex_reg, ex_next;
    logic signed [DIFF_W-1:0]    ey_reg, ey_next;
    logic [ANGLE_BITS-1:0]       yaw_a_reg, yaw_a_next;
    logic signed [YAW_EXT_W-1:0] yaw_ext;

    logic [DIFF_W-1:0]           abs_a, abs_b;
    logic [2*DIFF_W-1:0]         sq_a_full, sq_b_full;
    logic signed [CORD_W-1:0]    ex_w, ey_w;
    front_t                      front_reg, front_next;
    logic [ANGLE_BITS-1:0]       yaw_b_reg;

    // stage A: errors at full width, yaw taken modulo one turn
    always_comb
    begin
        ex_next    = DIFF_W'(goal_x) - DIFF_W'(robot_x);
        ey_next    = DIFF_W'(goal_y) - DIFF_W'(robot_y);
        yaw_ext    = YAW_EXT_W'(yaw_angle);
        yaw_a_next = yaw_ext[ANGLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            yaw_a_reg <= yaw_a_next;
        end
    end

    // stage B: squares for the root, half-plane fold for the CORDIC
    always_comb
    begin
        abs_a     = ex_reg[DIFF_W-1] ? DIFF_W'(-ex_reg) : DIFF_W'(ex_reg);
        abs_b     = ey_reg[DIFF_W-1] ? DIFF_W'(-ey_reg) : DIFF_W'(ey_reg);
        sq_a_full = abs_a * abs_a;
        sq_b_full = abs_b * abs_b;
        ex_w      = CORD_W'(ex_reg);
        ey_w      = CORD_W'(ey_reg);

        front_next.sq_a    = sq_a_full[SQ_W-1:0];
        front_next.sq_b    = sq_b_full[SQ_W-1:0];
        front_next.cx      = ex_reg[DIFF_W-1] ? -ex_w : ex_w;
        front_next.cy      = ex_reg[DIFF_W-1] ? -ey_w : ey_w;
        front_next.cz      = ex_reg[DIFF_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : '0;
        front_next.at_goal = (ex_reg == '0) && (ey_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
            yaw_b_reg <= yaw_a_reg;
        end
    end

    assign front = front_reg;
    assign yaw_w = yaw_b_reg;

endmodule

[hw/rtl/ggpc_sqrt.sv]
// ----------------------------------------------------------------------------
// ggpc_sqrt
// Sum of squares and pipelined restoring square root, one root bit a stage.
// ----------------------------------------------------------------------------
module ggpc_sqrt
    import ggpc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   sq_a,
    input  logic [SQ_W-1:0]   sq_b,
    output logic [ROOT_W-1:0] goal_dist
);

    logic [RAD_W-1:0]  rad_reg  [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= RAD_W'(sq_a) + RAD_W'(sq_b);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [REM_W-1:0] rem_t;
        logic [REM_W-1:0] trial;
        logic             take;

        always_comb
        begin
            // bring down the next two radicand bits, try root*4+1
            rem_t = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
            trial = REM_W'({root_reg[k], 2'b01});
            take  = (rem_t >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], take};
            end
        end

        if (k < ROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? (rem_t - trial) : rem_t;
                    rad_reg[k+1] <= {rad_reg[k][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign goal_dist = root_reg[ROOT_W];

endmodule

[hw/rtl/ggpc_cordic.sv]
// ----------------------------------------------------------------------------
// ggpc_cordic
// Pipelined vectoring CORDIC for the bearing, rounding to a binary angle and
// heading error against the wrapped yaw.
// ----------------------------------------------------------------------------
module ggpc_cordic
    import ggpc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  front_t                front,
    input  logic [ANGLE_BITS-1:0] yaw_w,
    output logic [ANGLE_BITS+2:0] mag5,
    output head_flags_t           flags
);

    localparam logic [Z_W-1:0] ROUND_HALF = Z_W'(1) << (Z_W - 1 - ANGLE_BITS);

    logic signed [CORD_W-1:0] x_reg    [0:CORDIC_ITERS-2];
    logic signed [CORD_W-1:0] y_reg    [0:CORDIC_ITERS-2];
    logic [Z_W-1:0]           z_reg    [0:CORDIC_ITERS-1];
    logic [ANGLE_BITS-1:0]    yaw_reg  [0:CORDIC_ITERS-1];
    logic                     goal_reg [0:CORDIC_ITERS-1];

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        logic signed [CORD_W-1:0] x_in, y_in, xs, ys;
        logic [Z_W-1:0]           z_in;
        logic [ANGLE_BITS-1:0]    yaw_in;
        logic                     goal_in;
        logic                     pos;

        if (i == 0)
        begin : g_first
            assign x_in    = front.cx;
            assign y_in    = front.cy;
            assign z_in    = front.cz;
            assign yaw_in  = yaw_w;
            assign goal_in = front.at_goal;
        end
        else
        begin : g_rest
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
            assign yaw_in  = yaw_reg[i-1];
            assign goal_in = goal_reg[i-1];
        end

        always_comb
        begin
            xs  = x_in >>> i;
            ys  = y_in >>> i;
            pos = ~y_in[CORD_W-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[i]    <= pos ? (z_in + ATAN_TAB[i]) : (z_in - ATAN_TAB[i]);
                yaw_reg[i]  <= yaw_in;
                goal_reg[i] <= goal_in;
            end
        end

        if (i < CORDIC_ITERS - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= pos ? (x_in + ys) : (x_in - ys);
                    y_reg[i] <= pos ? (y_in - xs) : (y_in + xs);
                end
            end
        end
    end

    // round to nearest binary angle; a full turn wraps to zero
    logic [Z_W-1:0]          z_rnd;
    logic [ANGLE_BITS-1:0]   bearing_reg;
    logic [ANGLE_BITS-1:0]   yaw_c_reg;
    logic                    goal_c_reg;

    assign z_rnd = z_reg[CORDIC_ITERS-1] + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bearing_reg <= z_rnd[Z_W-1 -: ANGLE_BITS];
            yaw_c_reg   <= yaw_reg[CORDIC_ITERS-1];
            goal_c_reg  <= goal_reg[CORDIC_ITERS-1];
        end
    end

    // heading error, left unwrapped, as sign and magnitude times five
    logic [ANGLE_BITS:0]   diff;
    logic [ANGLE_BITS:0]   diff_abs;
    logic [ANGLE_BITS+2:0] mag5_next;
    logic [ANGLE_BITS+2:0] mag5_reg;
    head_flags_t           flags_reg;

    always_comb
    begin
        diff      = {1'b0, bearing_reg} - {1'b0, yaw_c_reg};
        diff_abs  = diff[ANGLE_BITS] ? (~diff + 1'b1) : diff;
        mag5_next = {diff_abs[ANGLE_BITS-1:0], 2'b00}
                  + (ANGLE_BITS+3)'(diff_abs[ANGLE_BITS-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag5_reg          <= mag5_next;
            flags_reg.neg     <= diff[ANGLE_BITS];
            flags_reg.at_goal <= goal_c_reg;
        end
    end

    assign mag5  = mag5_reg;
    assign flags = flags_reg;

endmodule

[hw/rtl/ggpc_cmd.sv]
// ----------------------------------------------------------------------------
// ggpc_cmd
// Gain products, scaling, saturation and the at-goal override (two stages).
// ----------------------------------------------------------------------------
module ggpc_cmd
    import ggpc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ROOT_W-1:0]     goal_dist,
    input  logic [ANGLE_BITS+2:0] mag5,
    input  head_flags_t           flags,
    input  logic [GAIN_W-1:0]     gain,
    output result_t               res
);

    localparam int MAG_W = ANGLE_BITS + 3;
    localparam int SAT_W = (MAG_W > ANG_W) ? MAG_W : ANG_W;

    logic [ROOT_W+GAIN_W-1:0] lin_prod_reg;
    logic [MAG_W+GAIN_W-1:0]  ang_prod_reg;
    head_flags_t              flags_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_prod_reg <= goal_dist * gain;
            ang_prod_reg <= mag5 * gain;
            flags_reg    <= flags;
        end
    end

    logic [SAT_W-1:0] mag_ext;
    logic [SAT_W-1:0] mag_sat;
    logic [ANG_W-1:0] ang_mag;
    result_t          res_next;
    result_t          res_reg;

    always_comb
    begin
        mag_ext = SAT_W'(ang_prod_reg[MAG_W+GAIN_W-1:GAIN_W]);
        mag_sat = (mag_ext > SAT_W'(ANG_MAX)) ? SAT_W'(ANG_MAX) : mag_ext;
        ang_mag = mag_sat[ANG_W-1:0];

        // gain times a 33-bit distance stays below the linear ceiling
        res_next.linear_cmd  = LIN_W'(lin_prod_reg[ROOT_W+GAIN_W-1:GAIN_W]);
        res_next.angular_cmd = flags_reg.neg ? (~ang_mag + 1'b1) : ang_mag;
        res_next.arrived     = 1'b0;

        if (flags_reg.at_goal)
        begin
            res_next.linear_cmd  = '0;
            res_next.angular_cmd = '0;
            res_next.arrived     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[hw/rtl/go_to_goal_p_controller.sv]
// ----------------------------------------------------------------------------
// go_to_goal_p_controller
// Proportional go-to-goal controller: odometry sample in, speed commands out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one odometry sample per transaction (robot x, y in
//   Q15.16, yaw as a binary angle). Master stream returns one command
//   transaction per sample: linear and angular command in tdata, the arrived
//   flag in tuser. Goal x, goal y and gain sit on the APB port at byte
//   addresses 0, 4 and 8; write them only while no sample is in flight.
//   Throughput is one sample per clock while the skid register is free.
//   A sample passes 39 register stages: two front stages (errors, squares),
//   34 stages set by the 33-step square root (the 32-iteration CORDIC plus
//   rounding and heading error runs beside it), two command stages and the
//   output register.
//   Reset empties the pipeline and loads goal (0, 0) and gain 6554 (0.1).
//   When the receiver stalls, a skid register takes one more result; after
//   that s_axis_tready drops and the whole pipeline holds until the skid
//   register drains.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller
    import ggpc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // odometry samples
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // robot_x[31:0], robot_y[63:32], yaw_angle[79:64]
    // commands
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // linear_cmd[33:0], angular_cmd[53:34], zero[55:54]
    output logic [0:0]  m_axis_tuser    // arrived[0]
);

    // ---------------- configuration registers ----------------
    logic signed [POS_W-1:0] goal_x_reg;
    logic signed [POS_W-1:0] goal_y_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic                    cfg_wr;
    reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GOAL_X: goal_x_reg <= pwdata;
                REG_GOAL_Y: goal_y_reg <= pwdata;
                REG_GAIN:   gain_reg   <= pwdata[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_GOAL_X: prdata = goal_x_reg;
            REG_GOAL_Y: prdata = goal_y_reg;
            REG_GAIN:   prdata = 32'(gain_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    logic                  adv;
    logic [PIPE_LAT-1:0]   valid_reg;
    front_t                front;
    logic [ANGLE_BITS-1:0] yaw_w;
    logic [ROOT_W-1:0]     goal_dist;
    logic [ANGLE_BITS+2:0] mag5;
    head_flags_t           flags;
    result_t               res;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    new_item;

    // the pipeline moves as a whole while the skid register is free
    assign adv           = ~skid_valid_reg;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    ggpc_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk       (clk),
        .en        (adv),
        .robot_x   (s_axis_tdata[31:0]),
        .robot_y   (s_axis_tdata[63:32]),
        .yaw_angle (s_axis_tdata[79:64]),
        .goal_x    (goal_x_reg),
        .goal_y    (goal_y_reg),
        .front     (front),
        .yaw_w     (yaw_w)
    );

    ggpc_sqrt u_sqrt (
        .clk       (clk),
        .en        (adv),
        .sq_a      (front.sq_a),
        .sq_b      (front.sq_b),
        .goal_dist (goal_dist)
    );

    ggpc_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk   (clk),
        .en    (adv),
        .front (front),
        .yaw_w (yaw_w),
        .mag5  (mag5),
        .flags (flags)
    );

    ggpc_cmd #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cmd (
        .clk       (clk),
        .en        (adv),
        .goal_dist (goal_dist),
        .mag5      (mag5),
        .flags     (flags),
        .gain      (gain_reg),
        .res       (res)
    );

    // ---------------- output register and skid ----------------
    assign new_item = valid_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= new_item;
        end
        else if (new_item)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (new_item)
            begin
                out_reg <= res;
            end
        end
        else if (new_item)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.angular_cmd, out_reg.linear_cmd};
    assign m_axis_tuser  = out_reg.arrived;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid register holds a result while output register is empty");

    a_skid_from_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready && new_item)
    ) else $error("skid register filled without a stalled output");

    a_hold_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_axis_tready |=> $stable(valid_reg)
    ) else $error("pipeline moved while skid register was full");

    a_arrived_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.arrived |->
            (out_reg.linear_cmd == '0) && (out_reg.angular_cmd == '0)
    ) else $error("arrived result carries nonzero commands");
`endif

endmodule
